[rtl/lhs_pkg.sv]
package lhs_pkg;

  // Field widths
  localparam int SAMPLE_W = 24;
  localparam int CFG_W    = 24;
  localparam int RB_W     = 10;
  localparam int CNT_W    = 32;
  localparam int SUM_W    = 64;
  localparam int SQ_W     = 2 * SAMPLE_W;
  localparam int MIN_W    = 30;

  // Stream payload layout
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_FIELD_W = RB_W + 3 * CNT_W - CNT_W + 2 * SAMPLE_W + 2 * SUM_W;
  localparam int OUT_TDATA_W = 256;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // Smallest-sample tracker starts above any sample
  localparam logic [MIN_W-1:0]    MIN_RESET  = 30'd999999999;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  // Configuration registers
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_WIDTH = 2'd2;

  localparam logic [CFG_W-1:0] RANGE_START_RST  = 24'd0;
  localparam logic [CFG_W-1:0] RANGE_END_RST    = 24'd10230;
  localparam logic [CFG_W-1:0] BUCKET_WIDTH_RST = 24'd10;

  // Request kinds carried in tuser
  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Serial divider
  localparam int DIV_W     = 24;
  localparam int DIV_CNT_W = 5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } store_ctl_t;

endpackage

[rtl/lhs_div.sv]
// Restoring divider, one quotient bit per cycle
module lhs_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lhs_pkg::DIV_W-1:0]  dividend,
  input  logic [lhs_pkg::DIV_W-1:0]  divisor,
  output lhs_pkg::div_stat_t         stat,
  output logic [lhs_pkg::DIV_W-1:0]  quotient
);
  import lhs_pkg::*;

  logic [DIV_W:0]     rem_r;
  logic [DIV_W-1:0]   quo_r;
  logic [DIV_W-1:0]   dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [DIV_W:0]     rem_sh;
  logic               ge;

  // Shift in next dividend bit and trial-subtract
  assign rem_sh = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? (rem_sh - {1'b0, dsr_r}) : rem_sh;
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

[rtl/lhs_store.sv]
// Bucket count memory with a clearing sweep after reset
module lhs_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lhs_pkg::store_ctl_t      ctl,
  input  logic [AW-1:0]            addr,
  input  logic [lhs_pkg::CNT_W-1:0] wdata,
  output logic [lhs_pkg::CNT_W-1:0] rd_data,
  output logic                     clear_busy
);
  import lhs_pkg::*;

  logic [CNT_W-1:0] mem_r [DEPTH];
  logic [CNT_W-1:0] rd_data_r;
  logic [AW-1:0]    clr_addr_r;
  logic             clearing_r;

  // Sweep one entry per cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clearing_r <= 1'b1;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Single write port
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem_r[clr_addr_r] <= '0;
    end else if (ctl.wr_en) begin
      mem_r[addr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem_r[addr];
    end
  end

  assign rd_data    = rd_data_r;
  assign clear_busy = clearing_r;

endmodule

[rtl/latency_histogram_stats.sv]
// Latency histogram with running statistics.
// Input stream (in_*): in_tuser selects the request kind, 0 adds a sample,
// 1 reads one bucket. in_tdata carries the sample and the bucket to read.
// Result stream (out_*): one result per request with the bucket index, its
// count, and the sample count, min, max, sum and sum of squares after it.
// Config port (cfg_*): range start, range end and bucket width, written
// while no request is in flight; the user must ensure this, the block does not.
// One request is processed at a time. An add runs the serial divider that
// forms the bucket index (one quotient bit a cycle), then a read and a
// write-back of the bucket memory and the result load. A read does one
// memory read (none for a bucket past the last) and the result load.
// Reset is synchronous. After reset the bucket memory is swept to zero, one
// entry a cycle, and in_tready stays low meanwhile.
// A result waits in the output register while out_tready is low; the next
// request is still accepted and worked on, and its result is held back
// until the output register is free.
module latency_histogram_stats #(
  parameter int NUM_BUCKETS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [23:0] sample_value, [33:24] read_bucket, [39:34] zero
  input  logic [lhs_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] func
  input  logic                              in_tuser,
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [9:0] bucket_index, [41:10] bucket_count, [73:42] sample_count,
  // [97:74] min_seen, [121:98] max_seen, [185:122] total_sum,
  // [249:186] square_sum, [255:250] zero
  output logic [lhs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // Configuration
  input  logic                              cfg_wr_en,
  input  logic [lhs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lhs_pkg::CFG_W-1:0]         cfg_wdata
);
  import lhs_pkg::*;

  localparam int AW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam logic [DIV_W-1:0] LAST_BUCKET = DIV_W'(NUM_BUCKETS - 1);

  // Config registers
  logic [CFG_W-1:0] range_start_r;
  logic [CFG_W-1:0] range_end_r;
  logic [CFG_W-1:0] bucket_width_r;

  // Control
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load_out;
  logic   div_start;
  logic   in_acc;

  // Request context
  logic               func_r;
  logic [SAMPLE_W-1:0] s_r;
  logic [AW-1:0]      idx_r;
  logic [RB_W-1:0]    oidx_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SQ_W-1:0]    sq_r;

  // Statistics
  logic [MIN_W-1:0]    smallest_r, smallest_nxt;
  logic [SAMPLE_W-1:0] largest_r, largest_nxt;
  logic [CNT_W-1:0]    taken_r, taken_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SUM_W-1:0]    sqsum_r, sqsum_nxt;
  logic [SAMPLE_W-1:0] min_out;

  logic [OUT_TDATA_W-1:0] out_data_r;

  // Input fields
  logic [SAMPLE_W-1:0] s_in;
  logic [RB_W-1:0]     rb_in;
  logic                rb_ok;

  // Divider
  logic [DIV_W-1:0] dvd;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] capped;
  div_stat_t        dstat;

  // Store
  store_ctl_t       sctl;
  logic [AW-1:0]    saddr;
  logic [CNT_W-1:0] swdata;
  logic [CNT_W-1:0] rd_data;
  logic [CNT_W-1:0] inc;
  logic             clear_busy;

  assign s_in   = in_tdata[SAMPLE_W-1:0];
  assign rb_in  = in_tdata[SAMPLE_W+RB_W-1:SAMPLE_W];
  assign rb_ok  = 32'(rb_in) < NUM_BUCKETS;
  assign in_acc = in_tvalid && in_tready;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_start_r  <= RANGE_START_RST;
      range_end_r    <= RANGE_END_RST;
      bucket_width_r <= BUCKET_WIDTH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RANGE_START:  range_start_r  <= cfg_wdata;
        CFG_RANGE_END:    range_end_r    <= cfg_wdata;
        CFG_BUCKET_WIDTH: bucket_width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Offset into the range, clamped at both ends
  always_comb begin
    if (s_in >= range_end_r) begin
      dvd = (range_end_r >= range_start_r) ? (range_end_r - range_start_r) : '0;
    end else if (s_in < range_start_r) begin
      dvd = '0;
    end else begin
      dvd = s_in - range_start_r;
    end
  end

  // Zero width counts as one
  assign dsr = (bucket_width_r == '0) ? DIV_W'(1) : bucket_width_r;

  lhs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .stat     (dstat),
    .quotient (quo)
  );

  assign capped = (quo > LAST_BUCKET) ? LAST_BUCKET : quo;

  // Saturating bucket increment
  assign inc = (rd_data != '1) ? (rd_data + 1'b1) : rd_data;

  lhs_store #(
    .DEPTH (NUM_BUCKETS),
    .AW    (AW)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (sctl),
    .addr       (saddr),
    .wdata      (swdata),
    .rd_data    (rd_data),
    .clear_busy (clear_busy)
  );

  // Sequencer: memory read, then (for an add) write-back in the next
  // cycle; the next request enters only after that, so no access overlaps
  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    div_start  = 1'b0;
    sctl       = '0;
    saddr      = idx_r;
    swdata     = inc;
    load_out   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        if (!clear_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == FUNC_ADD) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end else if (rb_ok) begin
            sctl.rd_en = 1'b1;
            saddr      = AW'(rb_in);
            state_nxt  = ST_RD_WAIT;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        if (dstat.done) begin
          sctl.rd_en = 1'b1;
          saddr      = AW'(capped);
          state_nxt  = ST_RD_WAIT;
        end
      end
      ST_RD_WAIT: begin
        if (func_r == FUNC_ADD) begin
          sctl.wr_en = 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign out_valid_nxt = load_out || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request context
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_tuser;
      s_r    <= s_in;
      oidx_r <= rb_in;
      cnt_r  <= '0;
    end
    if (state_r == ST_DIV && dstat.done) begin
      idx_r  <= AW'(capped);
      oidx_r <= RB_W'(capped);
    end
    if (state_r == ST_RD_WAIT) begin
      cnt_r <= (func_r == FUNC_ADD) ? inc : rd_data;
    end
    sq_r <= SQ_W'(s_r) * SQ_W'(s_r);
  end

  // Statistics after this request
  always_comb begin
    smallest_nxt = smallest_r;
    largest_nxt  = largest_r;
    taken_nxt    = taken_r;
    sum_nxt      = sum_r;
    sqsum_nxt    = sqsum_r;
    if (func_r == FUNC_ADD) begin
      if (MIN_W'(s_r) <= smallest_r) begin
        smallest_nxt = MIN_W'(s_r);
      end
      if (s_r >= largest_r) begin
        largest_nxt = s_r;
      end
      if (taken_r != '1) begin
        taken_nxt = taken_r + 1'b1;
      end
      sum_nxt   = sum_r + SUM_W'(s_r);
      sqsum_nxt = sqsum_r + SUM_W'(sq_r);
    end
  end

  // Min saturates to the field width
  assign min_out = (smallest_nxt > MIN_W'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                      : smallest_nxt[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smallest_r <= MIN_RESET;
      largest_r  <= '0;
      taken_r    <= '0;
      sum_r      <= '0;
      sqsum_r    <= '0;
    end else if (load_out) begin
      smallest_r <= smallest_nxt;
      largest_r  <= largest_nxt;
      taken_r    <= taken_nxt;
      sum_r      <= sum_nxt;
      sqsum_r    <= sqsum_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, sqsum_nxt, sum_nxt, largest_nxt, min_out,
                     taken_nxt, cnt_r, oidx_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/lhs_checker.sv]
// Port-level checks for the histogram block
module lhs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lhs_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lhs_pkg::*;

  logic [CNT_W-1:0]    scnt;
  logic [SAMPLE_W-1:0] min_f;
  logic [SAMPLE_W-1:0] max_f;

  assign scnt  = out_tdata[73:42];
  assign min_f = out_tdata[97:74];
  assign max_f = out_tdata[121:98];

  // A stalled result keeps its valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result valid dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  // Reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // One request in flight at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted back to back");

  // Once samples exist, min never exceeds max
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (scnt != '0) |-> min_f <= max_f)
    else $error("min above max");

endmodule

bind latency_histogram_stats lhs_checker u_lhs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[tb/testbench.sv]
module testbench;
  import lhs_pkg::*;

  localparam int N_BUCKETS       = 1024;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 40;

  // One result: bucket touched plus the running statistics after the request
  typedef struct packed {
    logic [RB_W-1:0]     bucket_index;
    logic [CNT_W-1:0]    bucket_count;
    logic [CNT_W-1:0]    sample_count;
    logic [SAMPLE_W-1:0] min_seen;
    logic [SAMPLE_W-1:0] max_seen;
    logic [SUM_W-1:0]    total_sum;
    logic [SUM_W-1:0]    square_sum;
  } stats_t;

  // Directed table row: a register write or a request, with an optional
  // hand-typed result
  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_sel;
    logic                 func;
    logic [SAMPLE_W-1:0]  value;
    logic [RB_W-1:0]      bucket;
    logic                 typed;
    stats_t               want;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [23:0] sample_value, [33:24] read_bucket
  logic                   in_tuser = 1'b0; // [0] func
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [9:0] bucket_index, [41:10] bucket_count, [73:42] sample_count,
  // [97:74] min_seen, [121:98] max_seen, [185:122] total_sum, [249:186] square_sum
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  // Predicted histogram state and register copy
  logic [CNT_W-1:0]    bucket_tally [N_BUCKETS];
  logic [MIN_W-1:0]    smallest_seen;
  logic [SAMPLE_W-1:0] largest_seen;
  logic [CNT_W-1:0]    samples_added;
  logic [SUM_W-1:0]    sample_total;
  logic [SUM_W-1:0]    square_total;
  logic [CFG_W-1:0]    range_lo;
  logic [CFG_W-1:0]    range_hi;
  logic [CFG_W-1:0]    bin_width;
  logic [RB_W-1:0]     last_bucket = '0;

  stats_t      pending_stats [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned ready_run = 0;
  bit          stall_on = 1'b0;

  latency_histogram_stats #(.NUM_BUCKETS(N_BUCKETS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Predict one request and update the histogram state
  function automatic stats_t histogram_step(logic func, logic [SAMPLE_W-1:0] s,
                                            logic [RB_W-1:0] rb);
    stats_t      r;
    int unsigned w;
    int unsigned idx;
    if (func == FUNC_ADD) begin
      if (s >= largest_seen) largest_seen = s;
      if (s <= smallest_seen) smallest_seen = MIN_W'(s);
      // zero width behaves as one
      w = (bin_width == 0) ? 1 : bin_width;
      if (s >= range_hi) idx = (range_hi >= range_lo) ? (range_hi - range_lo) / w : 0;
      else if (s < range_lo) idx = 0;
      else idx = (s - range_lo) / w;
      if (idx > N_BUCKETS - 1) idx = N_BUCKETS - 1;
      if (bucket_tally[idx] != '1) bucket_tally[idx]++;
      if (samples_added != '1) samples_added++;
      sample_total += SUM_W'(s);
      square_total += SUM_W'(s) * SUM_W'(s);
      r.bucket_index = idx[RB_W-1:0];
      r.bucket_count = bucket_tally[idx];
    end else begin
      r.bucket_index = rb;
      r.bucket_count = bucket_tally[rb];
    end
    r.sample_count = samples_added;
    // the min tracker starts above any sample and reads back saturated
    r.min_seen = (smallest_seen > MIN_W'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                       : smallest_seen[SAMPLE_W-1:0];
    r.max_seen   = largest_seen;
    r.total_sum  = sample_total;
    r.square_sum = square_total;
    return r;
  endfunction

  function automatic stim_row_t req_row(logic func, logic [SAMPLE_W-1:0] sample,
                                        logic [RB_W-1:0] bucket);
    stim_row_t r;
    r = '0;
    r.func   = func;
    r.value  = sample;
    r.bucket = bucket;
    return r;
  endfunction

  function automatic stim_row_t checked_row(logic func, logic [SAMPLE_W-1:0] sample,
                                            logic [RB_W-1:0] bucket, stats_t want);
    stim_row_t r;
    r = req_row(func, sample, bucket);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] sel, logic [CFG_W-1:0] val);
    stim_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.reg_sel = sel;
    r.value   = val;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                results_seen, name, got, want));
  endtask

  // Drive one request, wait for the handshake, queue its prediction
  task automatic send_request(stim_row_t row);
    stats_t predicted;
    in_tvalid <= 1'b1;
    in_tuser  <= row.func;
    in_tdata  <= IN_TDATA_W'({row.bucket, row.value});
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    predicted = histogram_step(row.func, row.value, row.bucket);
    if (row.func == FUNC_ADD) last_bucket = predicted.bucket_index;
    pending_stats.push_back(row.typed ? row.want : predicted);
  endtask

  // Every request yields a result, so an empty queue means the block is idle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] sel, logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (sel)
      CFG_RANGE_START:  range_lo = val;
      CFG_RANGE_END:    range_hi = val;
      CFG_BUCKET_WIDTH: bin_width = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Receiver: ready and stall runs of random length in turn, if stall_on; else ready
  always @(posedge clk) begin
    if (!stall_on) begin
      out_tready <= 1'b1;
    end else if (ready_run != 0) begin
      ready_run <= ready_run - 1;
    end else begin
      out_tready <= !out_tready;
      if (!out_tready) ready_run <= $urandom_range(0, 12);
      else if ($urandom_range(0, 3) == 0) ready_run <= $urandom_range(0, 40);
      else ready_run <= $urandom_range(0, 4);
    end
  end

  // Result check against the oldest queued prediction
  always @(posedge clk) begin : result_check
    stats_t got;
    stats_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.bucket_index = out_tdata[9:0];
      got.bucket_count = out_tdata[41:10];
      got.sample_count = out_tdata[73:42];
      got.min_seen     = out_tdata[97:74];
      got.max_seen     = out_tdata[121:98];
      got.total_sum    = out_tdata[185:122];
      got.square_sum   = out_tdata[249:186];
      if (pending_stats.size() == 0) begin
        report_mismatch($sformatf("result with none pending, bucket %0d",
                                  got.bucket_index));
      end else begin
        want = pending_stats.pop_front();
        check_field("bucket_index", got.bucket_index, want.bucket_index);
        check_field("bucket_count", got.bucket_count, want.bucket_count);
        check_field("sample_count", got.sample_count, want.sample_count);
        check_field("min_seen", got.min_seen, want.min_seen);
        check_field("max_seen", got.max_seen, want.max_seen);
        check_field("total_sum", got.total_sum, want.total_sum);
        check_field("square_sum", got.square_sum, want.square_sum);
      end
      results_seen++;
    end
  end

  // Watchdog: ends the run when no request moves on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("[%0t] timeout: no handshake for %0d cycles, %0d results pending",
               $time, idle_cycles, pending_stats.size());
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned w;
    longint unsigned ew;
    longint unsigned v;
    int unsigned     pick;
    int unsigned     burst_left;
    bit              gaps_on;
    stim_row_t       row;

    // Predictor starts from the reset state
    for (int i = 0; i < N_BUCKETS; i++) bucket_tally[i] = '0;
    smallest_seen = MIN_RESET;
    largest_seen  = '0;
    samples_added = '0;
    sample_total  = '0;
    square_total  = '0;
    range_lo      = RANGE_START_RST;
    range_hi      = RANGE_END_RST;
    bin_width     = BUCKET_WIDTH_RST;

    // Empty histogram: nothing counted, min saturated
    directed_rows.push_back(checked_row(FUNC_READ, 24'd0, 10'd0,
        '{10'd0, 32'd0, 32'd0, SAMPLE_MAX, 24'd0, 64'd0, 64'd0}));
    directed_rows.push_back(checked_row(FUNC_READ, SAMPLE_MAX, 10'd1023,
        '{10'd1023, 32'd0, 32'd0, SAMPLE_MAX, 24'd0, 64'd0, 64'd0}));
    // Sample extremes under the reset range
    directed_rows.push_back(checked_row(FUNC_ADD, 24'd0, 10'd1023,
        '{10'd0, 32'd1, 32'd1, 24'd0, 24'd0, 64'd0, 64'd0}));
    directed_rows.push_back(checked_row(FUNC_ADD, SAMPLE_MAX, 10'd0,
        '{10'd1023, 32'd1, 32'd2, 24'd0, SAMPLE_MAX, 64'hFF_FFFF, 64'hFFFF_FE00_0001}));
    // Bucket edges around the range end and the first bucket boundary
    directed_rows.push_back(req_row(FUNC_ADD, 24'd10230, 10'd0));
    directed_rows.push_back(req_row(FUNC_ADD, 24'd10229, 10'd0));
    directed_rows.push_back(req_row(FUNC_ADD, 24'd9, 10'd0));
    directed_rows.push_back(req_row(FUNC_ADD, 24'd10, 10'd0));
    directed_rows.push_back(req_row(FUNC_READ, 24'd0, 10'd0));
    directed_rows.push_back(req_row(FUNC_READ, 24'h55_5555, 10'd1));
    directed_rows.push_back(req_row(FUNC_READ, 24'd0, 10'd1022));
    directed_rows.push_back(req_row(FUNC_READ, 24'd0, 10'd1023));
    // Alternating bit patterns on every field
    directed_rows.push_back(req_row(FUNC_ADD, 24'h55_5555, 10'h2AA));
    directed_rows.push_back(req_row(FUNC_ADD, 24'hAA_AAAA, 10'h155));
    directed_rows.push_back(req_row(FUNC_READ, 24'hAA_AAAA, 10'h155));
    directed_rows.push_back(req_row(FUNC_READ, 24'h55_5555, 10'h2AA));
    // Zero width acts as one; large indexes clamp to the last bucket
    directed_rows.push_back(cfg_row(CFG_BUCKET_WIDTH, 24'd0));
    directed_rows.push_back(req_row(FUNC_ADD, 24'd1022, 10'd0));
    directed_rows.push_back(req_row(FUNC_ADD, 24'd5000, 10'd0));
    directed_rows.push_back(req_row(FUNC_READ, 24'd0, 10'd1023));
    // End below start: the end bucket is zero
    directed_rows.push_back(cfg_row(CFG_RANGE_START, SAMPLE_MAX));
    directed_rows.push_back(cfg_row(CFG_RANGE_END, 24'd0));
    directed_rows.push_back(req_row(FUNC_ADD, 24'd5, 10'd0));
    directed_rows.push_back(req_row(FUNC_ADD, SAMPLE_MAX, 10'd0));
    directed_rows.push_back(req_row(FUNC_READ, 24'd0, 10'd0));
    // Widest buckets
    directed_rows.push_back(cfg_row(CFG_RANGE_START, 24'd100));
    directed_rows.push_back(cfg_row(CFG_RANGE_END, SAMPLE_MAX));
    directed_rows.push_back(cfg_row(CFG_BUCKET_WIDTH, SAMPLE_MAX));
    directed_rows.push_back(req_row(FUNC_ADD, 24'd99, 10'd0));
    directed_rows.push_back(req_row(FUNC_ADD, SAMPLE_MAX - 24'd1, 10'd0));
    directed_rows.push_back(req_row(FUNC_ADD, 24'd1, 10'd0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, back to back with receiver stalls
    stall_on = 1'b1;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_idle();
        write_register(directed_rows[i].reg_sel, directed_rows[i].value);
      end else begin
        send_request(directed_rows[i]);
      end
    end

    // Random phases, each under a new range setting
    for (int phase = 0; phase < N_PHASES; phase++) begin
      wait_idle();
      gaps_on  = (phase % 4) < 2;
      stall_on = (phase % 2) == 0;

      pick = $urandom_range(0, 9);
      if (phase == 0) w = 1;
      else if (pick == 0) w = 0;
      else if (pick < 5) w = $urandom_range(1, 64);
      else if (pick < 8) w = $urandom_range(1, 4096);
      else if (pick == 8) w = SAMPLE_MAX;
      else w = $urandom_range(1, SAMPLE_MAX);
      ew = (w == 0) ? 1 : w;

      pick = $urandom_range(0, 5);
      if (phase == 0 || pick == 0) lo = 0;
      else if (pick < 3) lo = $urandom_range(0, 1000);
      else if (pick < 5) lo = $urandom_range(0, SAMPLE_MAX);
      else lo = SAMPLE_MAX;

      pick = $urandom_range(0, 9);
      if (pick < 7) hi = lo + ew * $urandom_range(1, 1100);
      else if (pick == 7) hi = SAMPLE_MAX;
      else if (pick == 8) hi = $urandom_range(0, SAMPLE_MAX);
      else hi = (lo == 0) ? 0 : $urandom_range(0, lo - 1);
      if (hi > SAMPLE_MAX) hi = SAMPLE_MAX;

      write_register(CFG_RANGE_START, lo[CFG_W-1:0]);
      write_register(CFG_RANGE_END, hi[CFG_W-1:0]);
      write_register(CFG_BUCKET_WIDTH, w[CFG_W-1:0]);

      burst_left = $urandom_range(1, 16);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (burst_left == 0) begin
          if (gaps_on) begin
            in_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
          end
          burst_left = $urandom_range(1, 16);
        end
        burst_left--;

        if ($urandom_range(0, 9) < 3) begin
          // reads favor the bucket hit last so counts are nonzero
          row = req_row(FUNC_READ, 24'($urandom),
                        $urandom_range(0, 1) ? last_bucket : 10'($urandom));
        end else begin
          // samples spread over extremes, below-start, range edges, in-range and anywhere
          pick = $urandom_range(0, 99);
          if (pick < 8) v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
          else if (pick < 18) v = (lo == 0) ? 0 : $urandom_range(0, lo - 1);
          else if (pick < 33) v = (hi != 0 && $urandom_range(0, 1)) ? hi - 1
                                                                   : hi + $urandom_range(0, 3);
          else if (pick < 88) v = lo + ew * $urandom_range(0, 1100) + $urandom_range(0, ew - 1);
          else v = $urandom_range(0, SAMPLE_MAX);
          if (v > SAMPLE_MAX) v = SAMPLE_MAX;
          row = req_row(FUNC_ADD, v[SAMPLE_W-1:0], 10'($urandom));
        end
        send_request(row);
      end
    end

    // Drain; anything still pending trips the watchdog
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

[files.f]
rtl/lhs_pkg.sv
rtl/lhs_div.sv
rtl/lhs_store.sv
rtl/latency_histogram_stats.sv
rtl/lhs_checker.sv
tb/testbench.sv
